### rtl/core/assert_macros.svh
// Assertion helpers. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ALSH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ALSH_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/alsh_pkg.sv
package alsh_pkg;

    localparam int NUM_CPUS     = 2;
    localparam int CPU_W        = 1;
    localparam int REGS_PER_CPU = 16;
    localparam int REG_W        = 4;
    localparam int DATA_W       = 32;
    localparam int RF_DEPTH     = NUM_CPUS * REGS_PER_CPU;
    localparam int RF_AW        = $clog2(RF_DEPTH);

    localparam logic [REG_W-1:0] PC_REG = 4'd15;

    // Bit positions in the N Z C V flag nibble
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0,
        OP_MVN = 4'd1,
        OP_AND = 4'd2,
        OP_TST = 4'd3,
        OP_EOR = 4'd4,
        OP_TEQ = 4'd5,
        OP_ORR = 4'd6,
        OP_BIC = 4'd7,
        OP_ADD = 4'd8,
        OP_UND = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

    typedef logic [3:0] flags_t;

    // Decoded instruction held in the execute stage
    typedef struct packed {
        logic [3:0]        opcode;
        logic [CPU_W-1:0]  cpu;
        logic              imm_form;
        logic              set_flags;
        logic [3:0]        flag_mask;
        logic [REG_W-1:0]  dest_reg;
        shift_t            shift_kind;
        logic              shift_by_register;
        logic [DATA_W-1:0] immediate;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] rn_val;
        logic [DATA_W-1:0] rm_val;
        logic [DATA_W-1:0] rs_val;
    } operands_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              carry;
    } op2_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              writes;
        logic              trap;
        logic              upd;
        flags_t            flags;
    } alu_out_t;

endpackage

### rtl/core/alsh_cmd_if.sv
interface alsh_cmd_if;
    import alsh_pkg::*;

    logic              valid;
    logic              ready;
    logic [3:0]        opcode;
    logic              cpu_select;
    logic              imm_form;
    logic              set_flags;
    logic [3:0]        flag_mask;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  first_reg;
    logic [REG_W-1:0]  shifted_reg;
    logic [REG_W-1:0]  amount_reg;
    logic [1:0]        shift_kind;
    logic              shift_by_register;
    logic [DATA_W-1:0] immediate;

    modport source (
        output valid, opcode, cpu_select, imm_form, set_flags, flag_mask, dest_reg,
               first_reg, shifted_reg, amount_reg, shift_kind, shift_by_register,
               immediate,
        input  ready
    );

    modport sink (
        input  valid, opcode, cpu_select, imm_form, set_flags, flag_mask, dest_reg,
               first_reg, shifted_reg, amount_reg, shift_kind, shift_by_register,
               immediate,
        output ready
    );
endinterface

### rtl/core/alsh_rsp_if.sv
interface alsh_rsp_if;
    import alsh_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              register_written;
    logic              negative_flag;
    logic              zero_flag;
    logic              carry_flag;
    logic              overflow_flag;
    logic              undefined_trap;

    modport source (
        output valid, result_value, register_written, negative_flag, zero_flag,
               carry_flag, overflow_flag, undefined_trap,
        input  ready
    );

    modport sink (
        input  valid, result_value, register_written, negative_flag, zero_flag,
               carry_flag, overflow_flag, undefined_trap,
        output ready
    );
endinterface

### rtl/core/alsh_ram.sv
module alsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/alsh_regfile.sv
module alsh_regfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [alsh_pkg::RF_AW-1:0]     rn_addr,
    input  logic [alsh_pkg::RF_AW-1:0]     rm_addr,
    input  logic [alsh_pkg::RF_AW-1:0]     rs_addr,
    input  logic                           wr_en,
    input  logic [alsh_pkg::RF_AW-1:0]     wr_addr,
    input  logic [alsh_pkg::DATA_W-1:0]    wr_data,
    output alsh_pkg::operands_t            ops
);
    import alsh_pkg::*;

    localparam int NPORTS = 3;

    logic [RF_AW-1:0]  raddr      [NPORTS];
    logic [DATA_W-1:0] rdata      [NPORTS];
    logic [DATA_W-1:0] rval       [NPORTS];
    logic [RF_AW-1:0]  raddr_reg  [NPORTS];
    logic [NPORTS-1:0] rvalid_reg;
    logic [RF_DEPTH-1:0] valid_reg;
    logic              byp_en_reg;
    logic [RF_AW-1:0]  byp_addr_reg;
    logic [DATA_W-1:0] byp_data_reg;

    assign raddr[0] = rn_addr;
    assign raddr[1] = rm_addr;
    assign raddr[2] = rs_addr;

    // One bank per read port, all written alike
    for (genvar p = 0; p < NPORTS; p++)
    begin : g_bank
        alsh_ram #(
            .WIDTH (DATA_W),
            .DEPTH (RF_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (wr_en),
            .waddr (wr_addr),
            .wdata (wr_data),
            .re    (rd_en),
            .raddr (raddr[p]),
            .rdata (rdata[p])
        );

        always_ff @(posedge clk)
        begin
            if (rd_en)
            begin
                raddr_reg[p] <= raddr[p];
            end
        end

        // A write landing on the read edge is not in the bank output: forward it
        always_comb
        begin
            if (byp_en_reg && byp_addr_reg == raddr_reg[p])
            begin
                rval[p] = byp_data_reg;
            end
            else if (rvalid_reg[p])
            begin
                rval[p] = rdata[p];
            end
            else
            begin
                rval[p] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= '0;
            byp_en_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                for (int p = 0; p < NPORTS; p++)
                begin
                    rvalid_reg[p] <= valid_reg[raddr[p]];
                end
                byp_en_reg <= wr_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_data;
        end
    end

    assign ops.rn_val = rval[0];
    assign ops.rm_val = rval[1];
    assign ops.rs_val = rval[2];
endmodule

### rtl/core/alsh_shifter.sv
module alsh_shifter (
    input  alsh_pkg::item_t             item,
    input  logic [alsh_pkg::DATA_W-1:0] rm,
    input  logic [alsh_pkg::DATA_W-1:0] rs,
    input  logic                        cin,
    output alsh_pkg::op2_t              op2
);
    import alsh_pkg::*;

    logic [4:0]        amt;
    logic [7:0]        amt8;
    logic              amt_zero;
    logic [DATA_W-1:0] lsl_v;
    logic [DATA_W-1:0] lsr_v;
    logic [DATA_W-1:0] asr_v;
    logic [DATA_W-1:0] ror_v;
    logic              cl;
    logic              cr;
    logic              sign;
    logic              big;
    logic              exact32;

    assign amt8     = rs[7:0];
    assign amt      = item.shift_by_register ? amt8[4:0] : item.immediate[4:0];
    assign amt_zero = (amt == 5'd0);
    assign sign     = rm[DATA_W-1];
    assign big      = (amt8 >= 8'd32);
    assign exact32  = (amt8 == 8'd32);

    // Valid only for a nonzero amount
    assign lsl_v = rm << amt;
    assign lsr_v = rm >> amt;
    assign asr_v = DATA_W'($signed(rm) >>> amt);
    assign ror_v = (rm >> amt) | (rm << (6'd32 - {1'b0, amt}));
    assign cl    = rm[5'(6'd32 - {1'b0, amt})];
    assign cr    = rm[amt - 5'd1];

    always_comb
    begin
        op2.value = rm;
        op2.carry = cin;
        if (item.imm_form)
        begin
            op2.value = item.immediate;
            op2.carry = item.immediate[DATA_W-1];
        end
        else if (!item.shift_by_register)
        begin
            case (item.shift_kind)
                SH_LSL:
                begin
                    if (!amt_zero)
                    begin
                        op2.value = lsl_v;
                        op2.carry = cl;
                    end
                end
                SH_LSR:
                begin
                    op2.value = amt_zero ? '0 : lsr_v;
                    op2.carry = amt_zero ? sign : cr;
                end
                SH_ASR:
                begin
                    op2.value = amt_zero ? {DATA_W{sign}} : asr_v;
                    op2.carry = amt_zero ? sign : cr;
                end
                default:
                begin
                    // Amount zero is RRX
                    op2.value = amt_zero ? {cin, rm[DATA_W-1:1]} : ror_v;
                    op2.carry = amt_zero ? rm[0] : cr;
                end
            endcase
        end
        else if (amt8 != 8'd0)
        begin
            case (item.shift_kind)
                SH_LSL:
                begin
                    op2.value = big ? '0 : lsl_v;
                    op2.carry = big ? (exact32 & rm[0]) : cl;
                end
                SH_LSR:
                begin
                    op2.value = big ? '0 : lsr_v;
                    op2.carry = big ? (exact32 & sign) : cr;
                end
                SH_ASR:
                begin
                    op2.value = big ? {DATA_W{sign}} : asr_v;
                    op2.carry = big ? sign : cr;
                end
                default:
                begin
                    // Nonzero multiple of 32 keeps the value
                    op2.value = amt_zero ? rm : ror_v;
                    op2.carry = amt_zero ? sign : cr;
                end
            endcase
        end
    end
endmodule

### rtl/core/alsh_alu.sv
module alsh_alu (
    input  alsh_pkg::item_t             item,
    input  logic [alsh_pkg::DATA_W-1:0] rn,
    input  alsh_pkg::op2_t              op2,
    input  alsh_pkg::flags_t            flags_cur,
    output alsh_pkg::alu_out_t          res
);
    import alsh_pkg::*;

    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] val;
    logic              writes;
    logic              trap;
    logic              is_add;
    logic              cout;
    logic              ovf;
    logic              upd;

    assign sum = {1'b0, rn} + {1'b0, op2.value};

    always_comb
    begin
        val    = '0;
        writes = 1'b0;
        trap   = 1'b0;
        is_add = 1'b0;
        cout   = op2.carry;
        ovf    = 1'b0;
        case (item.opcode)
            OP_MOV: begin val = op2.value;        writes = 1'b1; end
            OP_MVN: begin val = ~op2.value;       writes = 1'b1; end
            OP_AND: begin val = rn & op2.value;   writes = 1'b1; end
            OP_TST: begin val = rn & op2.value;                  end
            OP_EOR: begin val = rn ^ op2.value;   writes = 1'b1; end
            OP_TEQ: begin val = rn ^ op2.value;                  end
            OP_ORR: begin val = rn | op2.value;   writes = 1'b1; end
            OP_BIC: begin val = rn & ~op2.value;  writes = 1'b1; end
            OP_ADD:
            begin
                val    = sum[DATA_W-1:0];
                writes = 1'b1;
                is_add = 1'b1;
                cout   = sum[DATA_W];
                ovf    = ~(rn[DATA_W-1] ^ op2.value[DATA_W-1])
                         & (rn[DATA_W-1] ^ sum[DATA_W-1]);
            end
            default: trap = 1'b1;
        endcase
    end

    // Tests always update; writes only with S and not to the PC
    assign upd = !trap && (writes ? (item.set_flags && item.dest_reg != PC_REG) : 1'b1);

    always_comb
    begin
        res.result = val;
        res.writes = writes;
        res.trap   = trap;
        res.upd    = upd;
        res.flags  = flags_cur;
        if (upd)
        begin
            if (item.flag_mask[FLAG_N])
            begin
                res.flags[FLAG_N] = val[DATA_W-1];
            end
            if (item.flag_mask[FLAG_Z])
            begin
                res.flags[FLAG_Z] = (val == '0);
            end
            if (item.flag_mask[FLAG_C])
            begin
                res.flags[FLAG_C] = cout;
            end
            if (is_add && item.flag_mask[FLAG_V])
            begin
                res.flags[FLAG_V] = ovf;
            end
        end
    end
endmodule

### rtl/core/arm_logic_add_alu_with_shifter.sv
// Data-processing execute unit for two CPU contexts: MOV, MVN, AND, TST, EOR,
// TEQ, ORR, BIC and ADD with an immediate or barrel-shifted register operand,
// masked N/Z/C/V update, and an undefined-opcode trap. Throughput is one word
// per cycle while responses are taken; each word passes the execute stage and
// the response register. Rate is set by the register file: three replicated
// one-read-port banks read on the accept edge, with the write of the word
// ahead forwarded from a bypass register, so a dependent word may follow in
// the next cycle. The banks are cleared logically by per-entry valid bits
// at reset, so the unit is ready out of reset. Flags live in flops per CPU.
`include "assert_macros.svh"

module arm_logic_add_alu_with_shifter (
    input  logic      clk,
    input  logic      rst_n,
    alsh_cmd_if.sink  cmd,
    alsh_rsp_if.source rsp
);
    import alsh_pkg::*;

    logic                             accept;
    logic                             s1_go;
    logic                             s1_valid_reg;
    item_t                            s1_item_reg;
    item_t                            item_in;
    logic [CPU_W-1:0]                 cpu_in;
    operands_t                        ops;
    op2_t                             op2;
    alu_out_t                         alu_res;
    logic [NUM_CPUS-1:0][3:0]         flags_reg;
    flags_t                           flags_cur;
    logic                             rf_wr_en;
    logic [RF_AW-1:0]                 rf_wr_addr;
    logic                             rsp_valid_reg;
    alu_out_t                         rsp_reg;

    // Out-of-range CPU numbers fall back to context 0
    assign cpu_in = (32'(cmd.cpu_select) < NUM_CPUS) ? CPU_W'(cmd.cpu_select) : '0;

    always_comb
    begin
        item_in.opcode            = cmd.opcode;
        item_in.cpu               = cpu_in;
        item_in.imm_form          = cmd.imm_form;
        item_in.set_flags         = cmd.set_flags;
        item_in.flag_mask         = cmd.flag_mask;
        item_in.dest_reg          = cmd.dest_reg;
        item_in.shift_kind        = shift_t'(cmd.shift_kind);
        item_in.shift_by_register = cmd.shift_by_register;
        item_in.immediate         = cmd.immediate;
    end

    assign s1_go     = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_go;
    assign accept    = cmd.valid && cmd.ready;

    alsh_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rn_addr ({cpu_in, cmd.first_reg}),
        .rm_addr ({cpu_in, cmd.shifted_reg}),
        .rs_addr ({cpu_in, cmd.amount_reg}),
        .wr_en   (rf_wr_en),
        .wr_addr (rf_wr_addr),
        .wr_data (alu_res.result),
        .ops     (ops)
    );

    assign flags_cur = flags_reg[s1_item_reg.cpu];

    alsh_shifter u_shifter (
        .item (s1_item_reg),
        .rm   (ops.rm_val),
        .rs   (ops.rs_val),
        .cin  (flags_cur[FLAG_C]),
        .op2  (op2)
    );

    alsh_alu u_alu (
        .item      (s1_item_reg),
        .rn        (ops.rn_val),
        .op2       (op2),
        .flags_cur (flags_cur),
        .res       (alu_res)
    );

    assign rf_wr_en   = s1_go && alu_res.writes;
    assign rf_wr_addr = {s1_item_reg.cpu, s1_item_reg.dest_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s1_go)
            begin
                rsp_valid_reg <= 1'b1;
                if (alu_res.upd)
                begin
                    flags_reg[s1_item_reg.cpu] <= alu_res.flags;
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item_in;
        end
        if (s1_go)
        begin
            rsp_reg <= alu_res;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.result_value     = rsp_reg.result;
    assign rsp.register_written = rsp_reg.writes;
    assign rsp.negative_flag    = rsp_reg.flags[FLAG_N];
    assign rsp.zero_flag        = rsp_reg.flags[FLAG_Z];
    assign rsp.carry_flag       = rsp_reg.flags[FLAG_C];
    assign rsp.overflow_flag    = rsp_reg.flags[FLAG_V];
    assign rsp.undefined_trap   = rsp_reg.trap;

    `ALSH_NEVER(a_wr_without_advance, rf_wr_en && !s1_go, "register write while stage stalled")
    `ALSH_ASSERT(a_stage_holds, s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_item_reg), "stalled word lost")
    `ALSH_ASSERT(a_flags_hold, !s1_go |=> $stable(flags_reg), "flags changed with no word retiring")
    `ALSH_NEVER(a_trap_writes, s1_go && alu_res.trap && (alu_res.writes || alu_res.upd), "trap changed state")
endmodule
